>>> design/top_k_sorted_insert_table_defines.svh
// ----------------------------------------------------------------------------
// Top-K sorted insert table: assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TOP_K_SORTED_INSERT_TABLE_DEFINES_SVH
`define TOP_K_SORTED_INSERT_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a property at every rising clock edge outside reset
`define TKST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds
`define TKST_ASSERT_NEVER(lbl, expr, msg) \
  `TKST_ASSERT(lbl, !(expr), msg)

`else

`define TKST_ASSERT(lbl, prop, msg)
`define TKST_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

>>> design/tkst_pkg.sv
// ----------------------------------------------------------------------------
// Top-K sorted insert table: package
// Field widths, key limits, mode codes and controller/datapath bundles.
// ----------------------------------------------------------------------------
package tkst_pkg;

  localparam int PRIMARY_W    = 20;
  localparam int SECONDARY_W  = 14;
  localparam int TAG_W        = 16;
  localparam int MODE_W       = 2;
  localparam int RANK_W       = 4;
  localparam int RESULT_CNT_W = 5;

  // Keys above these limits saturate
  localparam logic [PRIMARY_W-1:0]   PRIMARY_MAX   = 20'd1000000;
  localparam logic [SECONDARY_W-1:0] SECONDARY_MAX = 14'd10000;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  // One stored entry
  typedef struct packed {
    logic [PRIMARY_W-1:0]   key;
    logic [SECONDARY_W-1:0] sec;
    logic [TAG_W-1:0]       tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controller to datapath commands
  typedef struct packed {
    logic cap;        // capture the request
    logic clear;      // empty the table
    logic rd_rank;    // read the entry at the requested rank
    logic rd_last;    // read the last entry
    logic chk;        // judge the candidate against the last entry
    logic scan_init;  // start a scan over the held entries
    logic scan;       // one scan step: compare, shift, place
    logic rd_take;    // capture read data into the result
    logic out_load;   // move the result into the output register
  } tkst_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              last_beaten;
    logic              scan_done;
    logic              out_free;
  } tkst_sts_t;

endpackage

>>> design/tkst_in_if.sv
// ----------------------------------------------------------------------------
// Top-K sorted insert table: request channel
// Valid/ready channel carrying one request.
// ----------------------------------------------------------------------------
interface tkst_in_if;
  import tkst_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [MODE_W-1:0]      mode;
  logic [PRIMARY_W-1:0]   primary_key;
  logic [SECONDARY_W-1:0] secondary_key;
  logic [TAG_W-1:0]       entry_tag;
  logic [RANK_W-1:0]      read_rank;

  modport source (
    output valid, mode, primary_key, secondary_key, entry_tag, read_rank,
    input  ready
  );

  modport sink (
    input  valid, mode, primary_key, secondary_key, entry_tag, read_rank,
    output ready
  );
endinterface

>>> design/tkst_out_if.sv
// ----------------------------------------------------------------------------
// Top-K sorted insert table: result channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface tkst_out_if;
  import tkst_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    accepted;
  logic [RESULT_CNT_W-1:0] placed_rank;
  logic [PRIMARY_W-1:0]    out_primary;
  logic [SECONDARY_W-1:0]  out_secondary;
  logic [TAG_W-1:0]        out_tag;
  logic                    out_valid;
  logic [RESULT_CNT_W-1:0] entry_count;

  modport source (
    output valid, accepted, placed_rank, out_primary, out_secondary, out_tag,
           out_valid, entry_count,
    input  ready
  );

  modport sink (
    input  valid, accepted, placed_rank, out_primary, out_secondary, out_tag,
           out_valid, entry_count,
    output ready
  );
endinterface

>>> design/tkst_ram.sv
// ----------------------------------------------------------------------------
// Top-K sorted insert table: generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tkst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/tkst_ctrl.sv
// ----------------------------------------------------------------------------
// Top-K sorted insert table: controller
// Sequences each request through check, scan, read and result hand-off.
// ----------------------------------------------------------------------------
module tkst_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tkst_pkg::tkst_sts_t sts_i,
  output tkst_pkg::tkst_cmd_t cmd_o
);
  import tkst_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CHK  = 5'b00010,
    S_SCAN = 5'b00100,
    S_RDAT = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Decode the next state and the datapath commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          case (sts_i.mode)
            MODE_INSERT: begin
              if (sts_i.full) begin
                cmd_o.rd_last = 1'b1;
                state_d       = S_CHK;
              end else begin
                cmd_o.scan_init = 1'b1;
                state_d         = S_SCAN;
              end
            end
            MODE_READ: begin
              cmd_o.rd_rank = 1'b1;
              state_d       = S_RDAT;
            end
            MODE_CLEAR: begin
              cmd_o.clear = 1'b1;
              state_d     = S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_CHK: begin
        cmd_o.chk = 1'b1;
        state_d   = sts_i.last_beaten ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_DONE;
        end
      end
      S_RDAT: begin
        cmd_o.rd_take = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/tkst_dp.sv
// ----------------------------------------------------------------------------
// Top-K sorted insert table: datapath
// Entry RAM, bottom-up compare-and-shift scan, count and result registers.
// ----------------------------------------------------------------------------
`include "top_k_sorted_insert_table_defines.svh"

module tkst_dp #(
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  tkst_pkg::tkst_cmd_t                    cmd_i,
  output tkst_pkg::tkst_sts_t                    sts_o,
  input  logic [tkst_pkg::MODE_W-1:0]            mode_i,
  input  logic [tkst_pkg::PRIMARY_W-1:0]         primary_key_i,
  input  logic [tkst_pkg::SECONDARY_W-1:0]       secondary_key_i,
  input  logic [tkst_pkg::TAG_W-1:0]             entry_tag_i,
  input  logic [tkst_pkg::RANK_W-1:0]            read_rank_i,
  input  logic                                   out_ready_i,
  output logic                                   out_vld_o,
  output logic                                   accepted_o,
  output logic [tkst_pkg::RESULT_CNT_W-1:0]      placed_rank_o,
  output logic [tkst_pkg::PRIMARY_W-1:0]         out_primary_o,
  output logic [tkst_pkg::SECONDARY_W-1:0]       out_secondary_o,
  output logic [tkst_pkg::TAG_W-1:0]             out_tag_o,
  output logic                                   out_valid_o,
  output logic [tkst_pkg::RESULT_CNT_W-1:0]      entry_count_o
);
  import tkst_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // Captured request
  logic [PRIMARY_W-1:0]   pk_q;
  logic [SECONDARY_W-1:0] sk_q;
  logic [TAG_W-1:0]       tag_q;
  logic                   hit_q;

  // Table state and scan pointers
  logic [CW-1:0] cnt_q;
  logic [AW-1:0] ptr_q;
  logic [AW-1:0] cmp_idx_q;
  logic          pend_q;

  // Result under construction
  logic                   res_acc_q;
  logic [CW-1:0]          res_placed_q;
  logic [PRIMARY_W-1:0]   res_op_q;
  logic [SECONDARY_W-1:0] res_os_q;
  logic [TAG_W-1:0]       res_ot_q;
  logic                   res_ov_q;

  // Output register
  logic                    out_vld_q;
  logic                    out_acc_q;
  logic [RESULT_CNT_W-1:0] out_placed_q;
  logic [PRIMARY_W-1:0]    out_op_q;
  logic [SECONDARY_W-1:0]  out_os_q;
  logic [TAG_W-1:0]        out_ot_q;
  logic                    out_ov_q;
  logic [RESULT_CNT_W-1:0] out_cnt_q;

  // RAM ports
  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_wdata;
  entry_t        rd_ent;

  logic [PRIMARY_W-1:0]   pk_sat;
  logic [SECONDARY_W-1:0] sk_sat;
  logic                   full;
  logic                   beats;
  logic                   last_beaten;
  logic                   scan_done;
  logic [AW-1:0]          pos_w;
  logic                   rank_hit;

  // Saturate incoming keys
  assign pk_sat = (primary_key_i > PRIMARY_MAX) ? PRIMARY_MAX : primary_key_i;
  assign sk_sat = (secondary_key_i > SECONDARY_MAX) ? SECONDARY_MAX : secondary_key_i;

  assign full     = (cnt_q == CW'(DEPTH));
  assign rank_hit = ({{CW{1'b0}}, read_rank_i} < {{RANK_W{1'b0}}, cnt_q});

  // Candidate ranks above the entry just read
  assign beats = (rd_ent.key < pk_q) || ((rd_ent.key == pk_q) && (rd_ent.sec < sk_q));
  assign last_beaten = (pk_q > rd_ent.key);

  // Scan ends at the first entry the candidate does not beat, or past the top
  assign scan_done = pend_q ? !beats : (ptr_q == '0);
  assign pos_w     = pend_q ? (cmp_idx_q + AW'(1)) : '0;

  assign sts_o.mode        = mode_i;
  assign sts_o.full        = full;
  assign sts_o.last_beaten = last_beaten;
  assign sts_o.scan_done   = scan_done;
  assign sts_o.out_free    = !out_vld_q || out_ready_i;

  // Drive the RAM: rank read, last-entry read, or one scan step
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = ptr_q - AW'(1);
    ram_we    = 1'b0;
    ram_waddr = cmp_idx_q + AW'(1);
    ram_wdata = rd_ent;
    if (cmd_i.rd_rank) begin
      ram_re    = 1'b1;
      ram_raddr = AW'(read_rank_i);
    end
    if (cmd_i.rd_last) begin
      ram_re    = 1'b1;
      ram_raddr = AW'(DEPTH - 1);
    end
    if (cmd_i.scan) begin
      if (scan_done) begin
        ram_we    = 1'b1;
        ram_waddr = pos_w;
        ram_wdata = '{key: pk_q, sec: sk_q, tag: tag_q};
      end else begin
        ram_we = pend_q;
        ram_re = (ptr_q != '0);
      end
    end
  end

  tkst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_ent)
  );

  // Control state: count, scan pending flag, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        cnt_q <= '0;
      end
      if (cmd_i.scan_init || cmd_i.chk) begin
        pend_q <= 1'b0;
      end
      if (cmd_i.scan) begin
        if (scan_done) begin
          pend_q <= 1'b0;
          if (!full) begin
            cnt_q <= cnt_q + CW'(1);
          end
        end else begin
          pend_q <= (ptr_q != '0);
        end
      end
      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload: request capture, scan pointers, result and output registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      pk_q         <= pk_sat;
      sk_q         <= sk_sat;
      tag_q        <= entry_tag_i;
      hit_q        <= rank_hit;
      res_acc_q    <= 1'b0;
      res_placed_q <= CW'(DEPTH);
      res_op_q     <= '0;
      res_os_q     <= '0;
      res_ot_q     <= '0;
      res_ov_q     <= 1'b0;
    end
    if (cmd_i.scan_init) begin
      ptr_q <= cnt_q[AW-1:0];
    end
    if (cmd_i.chk) begin
      ptr_q <= AW'(DEPTH - 1);
    end
    if (cmd_i.scan) begin
      if (scan_done) begin
        res_acc_q    <= 1'b1;
        res_placed_q <= CW'(pos_w);
      end else if (ptr_q != '0) begin
        ptr_q     <= ptr_q - AW'(1);
        cmp_idx_q <= ptr_q - AW'(1);
      end
    end
    if (cmd_i.rd_take && hit_q) begin
      res_op_q <= rd_ent.key;
      res_os_q <= rd_ent.sec;
      res_ot_q <= rd_ent.tag;
      res_ov_q <= 1'b1;
    end
    if (cmd_i.out_load) begin
      out_acc_q    <= res_acc_q;
      out_placed_q <= RESULT_CNT_W'(res_placed_q);
      out_op_q     <= res_op_q;
      out_os_q     <= res_os_q;
      out_ot_q     <= res_ot_q;
      out_ov_q     <= res_ov_q;
      out_cnt_q    <= RESULT_CNT_W'(cnt_q);
    end
  end

  assign out_vld_o       = out_vld_q;
  assign accepted_o      = out_acc_q;
  assign placed_rank_o   = out_placed_q;
  assign out_primary_o   = out_op_q;
  assign out_secondary_o = out_os_q;
  assign out_tag_o       = out_ot_q;
  assign out_valid_o     = out_ov_q;
  assign entry_count_o   = out_cnt_q;

  // Checks
  `TKST_ASSERT(a_cnt_bound, cnt_q <= CW'(DEPTH), "entry count above depth")
  `TKST_ASSERT(a_grow_on_place, (cmd_i.scan && scan_done && !full) |=> (cnt_q == $past(cnt_q) + CW'(1)), "count did not grow on placement")
  `TKST_ASSERT(a_load_when_free, cmd_i.out_load |-> (!out_vld_q || out_ready_i), "result overwrote a pending result")
  `TKST_ASSERT(a_take_after_read, cmd_i.rd_take |-> $past(cmd_i.rd_rank), "read data taken without a rank read")
  `TKST_ASSERT_NEVER(a_shift_range, pend_q && (cmp_idx_q >= AW'(DEPTH - 1)), "shift source at last slot")

endmodule

>>> design/top_k_sorted_insert_table.sv
// The insert scan reads one entry per cycle from the entry RAM, bottom up,
// shifting each beaten entry down one slot as it goes.
// The block handles one request at a time; the next is taken in the cycle after the result loads.
// Reset empties the table at once; the RAM needs no clearing pass.
// ----------------------------------------------------------------------------
// Top-K sorted insert table
// Keeps up to DEPTH entries sorted by score then coin count, with a tag.
// ----------------------------------------------------------------------------
module top_k_sorted_insert_table #(
  parameter int DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tkst_in_if.sink    in_i,
  tkst_out_if.source out_o
);
  import tkst_pkg::*;

  tkst_cmd_t cmd;
  tkst_sts_t sts;

  tkst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tkst_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .mode_i          (in_i.mode),
    .primary_key_i   (in_i.primary_key),
    .secondary_key_i (in_i.secondary_key),
    .entry_tag_i     (in_i.entry_tag),
    .read_rank_i     (in_i.read_rank),
    .out_ready_i     (out_o.ready),
    .out_vld_o       (out_o.valid),
    .accepted_o      (out_o.accepted),
    .placed_rank_o   (out_o.placed_rank),
    .out_primary_o   (out_o.out_primary),
    .out_secondary_o (out_o.out_secondary),
    .out_tag_o       (out_o.out_tag),
    .out_valid_o     (out_o.out_valid),
    .entry_count_o   (out_o.entry_count)
  );

endmodule

>>> tb/top_k_sorted_insert_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-K sorted insert table: result checker
// Watches the request and result channels. Keeps its own copy of the table,
// predicts the result of every accepted request and compares it field by
// field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module top_k_sorted_insert_table_checker #(
  parameter int DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  tkst_in_if   req_i,
  tkst_out_if  rsp_i,
  output int   fail_count_o,
  output int   pending_o
);
  import tkst_pkg::*;

  typedef struct packed {
    logic                    accepted;
    logic [RESULT_CNT_W-1:0] placed_rank;
    logic [PRIMARY_W-1:0]    out_primary;
    logic [SECONDARY_W-1:0]  out_secondary;
    logic [TAG_W-1:0]        out_tag;
    logic                    out_valid;
    logic [RESULT_CNT_W-1:0] entry_count;
  } table_result_t;

  // Shadow table, sorted by score then coin count
  logic [PRIMARY_W-1:0]   score_tbl [DEPTH];
  logic [SECONDARY_W-1:0] coin_tbl  [DEPTH];
  logic [TAG_W-1:0]       tag_tbl   [DEPTH];
  int                     held_cnt;

  table_result_t          result_q [$];
  table_result_t          want;
  int                     fails;

  function automatic void empty_table();
    for (int i = 0; i < DEPTH; i++) begin
      score_tbl[i] = '0;
      coin_tbl[i]  = '0;
      tag_tbl[i]   = '0;
    end
    held_cnt = 0;
  endfunction

  // Apply one request to the shadow table and return the result it causes
  function automatic table_result_t apply_request(
    logic [MODE_W-1:0]      mode,
    logic [PRIMARY_W-1:0]   score_raw,
    logic [SECONDARY_W-1:0] coins_raw,
    logic [TAG_W-1:0]       tag,
    logic [RANK_W-1:0]      rank
  );
    table_result_t          res;
    logic [PRIMARY_W-1:0]   score;
    logic [SECONDARY_W-1:0] coins;
    logic                   full;
    logic                   found;
    int                     kept;
    int                     pos;

    res             = '0;
    res.placed_rank = RESULT_CNT_W'(DEPTH);
    score = (score_raw > PRIMARY_MAX) ? PRIMARY_MAX : score_raw;
    coins = (coins_raw > SECONDARY_MAX) ? SECONDARY_MAX : coins_raw;

    case (mode)
      MODE_INSERT: begin
        full = (held_cnt >= DEPTH);
        if (!full || score > score_tbl[DEPTH-1]) begin
          kept  = full ? DEPTH - 1 : held_cnt;
          pos   = kept;
          found = 1'b0;
          // Find the first held entry that the new one beats
          for (int i = 0; i < kept; i++) begin
            if (!found && (score_tbl[i] < score ||
                           (score_tbl[i] == score && coin_tbl[i] < coins))) begin
              pos   = i;
              found = 1'b1;
            end
          end
          // Shift the lower entries down one slot, dropping the last when full
          for (int i = kept; i > pos; i--) begin
            score_tbl[i] = score_tbl[i-1];
            coin_tbl[i]  = coin_tbl[i-1];
            tag_tbl[i]   = tag_tbl[i-1];
          end
          score_tbl[pos] = score;
          coin_tbl[pos]  = coins;
          tag_tbl[pos]   = tag;
          if (!full) held_cnt++;
          res.accepted    = 1'b1;
          res.placed_rank = RESULT_CNT_W'(pos);
        end
      end
      MODE_READ: begin
        if (int'(rank) < held_cnt && int'(rank) < DEPTH) begin
          res.out_primary   = score_tbl[rank];
          res.out_secondary = coin_tbl[rank];
          res.out_tag       = tag_tbl[rank];
          res.out_valid     = 1'b1;
        end
      end
      MODE_CLEAR: begin
        empty_table();
      end
      default: begin
      end
    endcase

    res.entry_count = RESULT_CNT_W'(held_cnt);
    return res;
  endfunction

  function automatic int field_diff(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      return 1;
    end
    return 0;
  endfunction

  // Compare each result, then predict each new request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_table();
      result_q.delete();
      fails        = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (result_q.size() == 0) begin
          $error("result with no request outstanding");
          fails++;
        end else begin
          want  = result_q.pop_front();
          fails += field_diff("accepted", want.accepted, rsp_i.accepted);
          fails += field_diff("placed_rank", want.placed_rank, rsp_i.placed_rank);
          fails += field_diff("out_primary", want.out_primary, rsp_i.out_primary);
          fails += field_diff("out_secondary", want.out_secondary, rsp_i.out_secondary);
          fails += field_diff("out_tag", want.out_tag, rsp_i.out_tag);
          fails += field_diff("out_valid", want.out_valid, rsp_i.out_valid);
          fails += field_diff("entry_count", want.entry_count, rsp_i.entry_count);
        end
      end
      if (req_i.valid && req_i.ready) begin
        result_q.push_back(apply_request(req_i.mode, req_i.primary_key,
                                         req_i.secondary_key, req_i.entry_tag,
                                         req_i.read_rank));
      end
      fail_count_o <= fails;
      pending_o    <= result_q.size();
    end
  end

endmodule

>>> tb/top_k_sorted_insert_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-K sorted insert table: testbench
// Drives directed and random insert, read, clear and unused-mode requests, the
// random ones in three phases of random sender idling and result
// back-pressure, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module top_k_sorted_insert_table_tb;
  import tkst_pkg::*;

  localparam int                DEPTH        = 16;
  localparam int                PHASE_ITEMS  = 225;
  localparam int                CYCLE_LIMIT  = 400000;
  localparam int                DRAIN_CYCLES = DEPTH + 8;
  localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   cycle_cnt      = 0;
  int   fail_count;
  int   pending;

  tkst_in_if  req_if ();
  tkst_out_if rsp_if ();

  top_k_sorted_insert_table #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (rsp_if)
  );

  top_k_sorted_insert_table_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_i       (rsp_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stall the result channel at random
  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("top_k_sorted_insert_table: mismatch");
      $finish;
    end
  end

  // Present one request, idling first at random, and hold it until taken
  task automatic send_request(
    logic [MODE_W-1:0]      mode,
    logic [PRIMARY_W-1:0]   score,
    logic [SECONDARY_W-1:0] coins,
    logic [TAG_W-1:0]       tag,
    logic [RANK_W-1:0]      rank
  );
    while ($urandom_range(99, 0) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.mode          <= mode;
    req_if.primary_key   <= score;
    req_if.secondary_key <= coins;
    req_if.entry_tag     <= tag;
    req_if.read_rank     <= rank;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Mostly inserts with clustered keys so ties and a full table are common
  task automatic random_request();
    int                     pick;
    int                     key_kind;
    logic [MODE_W-1:0]      mode;
    logic [PRIMARY_W-1:0]   score;
    logic [SECONDARY_W-1:0] coins;

    pick     = $urandom_range(99, 0);
    key_kind = $urandom_range(9, 0);
    if (pick < 2)       mode = MODE_CLEAR;
    else if (pick < 5)  mode = MODE_UNUSED;
    else if (pick < 40) mode = MODE_READ;
    else                mode = MODE_INSERT;

    if (key_kind < 5) begin
      score = PRIMARY_W'($urandom_range(7, 0) * 125000);
      coins = SECONDARY_W'($urandom_range(3, 0) * 3000);
    end else if (key_kind < 8) begin
      score = PRIMARY_W'($urandom);
      coins = SECONDARY_W'($urandom);
    end else begin
      score = PRIMARY_W'($urandom_range(20'hFFFFF, 999990));
      coins = SECONDARY_W'($urandom_range(14'h3FFF, 9990));
    end
    send_request(mode, score, coins, TAG_W'($urandom), RANK_W'($urandom));
  endtask

  initial begin
    req_if.valid         <= 1'b0;
    req_if.mode          <= MODE_INSERT;
    req_if.primary_key   <= '0;
    req_if.secondary_key <= '0;
    req_if.entry_tag     <= '0;
    req_if.read_rank     <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, saturation, ties, fill, reject, evict, clear
    send_request(MODE_CLEAR, '0, '0, '0, '0);
    send_request(MODE_UNUSED, 20'd77, 14'd5, 16'd9, 4'd3);
    send_request(MODE_READ, '0, '0, '0, 4'd15);
    send_request(MODE_INSERT, 20'hFFFFF, 14'h3FFF, 16'hFFFF, 4'hF);
    send_request(MODE_INSERT, 20'd0, 14'd0, 16'd0, 4'd0);
    send_request(MODE_INSERT, PRIMARY_MAX, SECONDARY_MAX, 16'd1, 4'd0);
    send_request(MODE_INSERT, 20'd500000, 14'd5, 16'd2, 4'd0);
    send_request(MODE_INSERT, 20'd500000, 14'd5, 16'd3, 4'd0);
    send_request(MODE_INSERT, 20'd500000, 14'd6, 16'd4, 4'd0);
    for (int i = 1; i <= 10; i++) begin
      send_request(MODE_INSERT, PRIMARY_W'(i * 40000), SECONDARY_W'(i * 900),
                   TAG_W'(16'h100 + i), 4'd0);
    end
    send_request(MODE_INSERT, 20'd0, SECONDARY_MAX, 16'hAAAA, 4'd0);
    send_request(MODE_INSERT, 20'd1, 14'd0, 16'h5555, 4'd0);
    send_request(MODE_READ, '0, '0, '0, 4'd0);
    send_request(MODE_READ, '0, '0, '0, 4'd15);
    send_request(MODE_CLEAR, '0, '0, '0, '0);
    send_request(MODE_READ, '0, '0, '0, 4'd0);

    // Random: receiver stalls most, then sender idles most, then neither
    send_idle_pct  = 31;
    recv_stall_pct = 74;
    repeat (PHASE_ITEMS) random_request();
    send_idle_pct  = 74;
    recv_stall_pct = 31;
    repeat (PHASE_ITEMS) random_request();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (PHASE_ITEMS) random_request();
    req_if.valid <= 1'b0;

    // Drain outstanding results, then watch for strays
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("top_k_sorted_insert_table: match");
    end else begin
      $display("top_k_sorted_insert_table: mismatch");
    end
    $finish;
  end

endmodule
